@@ sv/pit_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pit_pkg
// Widths, command codes and controller/datapath interface types shared by
// the pausable interval timer.
// ----------------------------------------------------------------------------
package pit_pkg;

   localparam int IV_W   = 32;               // interval and time left
   localparam int NOW_W  = 40;               // timestamp and elapsed output
   localparam int ARG_W  = 32;               // command argument
   localparam int ST_W   = 42;               // start time and frozen elapsed
   localparam int RAW_W  = ST_W + 1;         // signed elapsed before clamping
   localparam int FRAC_W = 16;               // Q16.16 fraction bits
   localparam int DVD_W  = ST_W + FRAC_W;    // divider dividend and quotient
   localparam int CNT_W  = $clog2(DVD_W);    // divider step counter
   localparam int PROD_W = ARG_W + IV_W;     // set-progress product
   localparam int TIMES_W = 16;

   localparam logic [3:0] CMD_QUERY       = 4'd0;
   localparam logic [3:0] CMD_START       = 4'd1;
   localparam logic [3:0] CMD_PAUSE       = 4'd2;
   localparam logic [3:0] CMD_RESUME      = 4'd3;
   localparam logic [3:0] CMD_EXPIRE      = 4'd4;
   localparam logic [3:0] CMD_UNEXPIRE    = 4'd5;
   localparam logic [3:0] CMD_DELAY       = 4'd6;
   localparam logic [3:0] CMD_SET_PROG    = 4'd7;
   localparam logic [3:0] CMD_START_FRAC  = 4'd8;
   localparam logic [3:0] CMD_START_REST  = 4'd9;

   typedef struct packed {
      logic capture;     // latch the accepted request
      logic div_start;   // launch a division of the current elapsed time
      logic mul_en;      // register the set-progress product
      logic apply;       // update the timer state
      logic load_rsp;    // load the response register
   } ctl_cmd_type;

   typedef struct packed {
      logic need_pre;    // command needs elapsed mod interval first
      logic need_mul;    // command needs the set-progress product
      logic div_done;    // divider result ready
      logic out_free;    // response register can take a new beat
   } dp_status_type;

endpackage
`default_nettype wire

@@ sv/pit_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pit_divider
// Restoring divider, one quotient bit per cycle. Divides the elapsed time
// extended by sixteen fraction bits by the interval, and keeps the integer
// remainder seen once all integer bits have been consumed.
// ----------------------------------------------------------------------------
module pit_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pit_pkg::ST_W-1:0]    dividend,
   input  wire logic [pit_pkg::IV_W-1:0]    divisor,
   output logic                             done,
   output logic [pit_pkg::DVD_W-1:0]        quotient,
   output logic [pit_pkg::IV_W-1:0]         int_rem
);
   import pit_pkg::*;

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [IV_W-1:0]  rem_ff, rem_in;
   logic [IV_W-1:0]  mod_ff, mod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [IV_W:0]    shifted;
   logic [IV_W:0]    diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         dvd_in  = {dividend, {FRAC_W{1'b0}}};
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[IV_W-1:0] : shifted[IV_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         // integer bits exhausted: this is elapsed mod interval
         if (cnt_ff == CNT_W'(ST_W - 1)) begin
            mod_in = rem_in;
         end
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      mod_ff <= mod_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
   assign int_rem  = mod_ff;

endmodule
`default_nettype wire

@@ sv/pit_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pit_datapath
// Timer state, interval register, request capture, set-progress multiplier,
// divider and response register with all result arithmetic.
// ----------------------------------------------------------------------------
module pit_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pit_pkg::ctl_cmd_type          ctl,
   output pit_pkg::dp_status_type             status,
   input  wire logic                          cfg_we,
   input  wire logic [pit_pkg::IV_W-1:0]      cfg_data,
   input  wire logic [3:0]                    req_cmd,
   input  wire logic [pit_pkg::NOW_W-1:0]     req_now_ms,
   input  wire logic signed [pit_pkg::ARG_W-1:0] req_arg,
   input  wire logic                          req_clamp_progress,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic                               rsp_expired,
   output logic                               rsp_is_paused,
   output logic                               rsp_started,
   output logic [pit_pkg::NOW_W-1:0]          rsp_elapsed_ms,
   output logic [pit_pkg::IV_W-1:0]           rsp_progress,
   output logic [pit_pkg::TIMES_W-1:0]        rsp_times_expired,
   output logic [pit_pkg::IV_W-1:0]           rsp_time_left_ms
);
   import pit_pkg::*;

   localparam logic [IV_W-1:0]   PROG_ONE  = IV_W'(1) << FRAC_W;
   localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (FRAC_W - 1);

   // configuration and architectural state
   logic [IV_W-1:0]  iv_ff, iv_in;
   logic [ST_W-1:0]  start_ff, start_in;
   logic [ST_W-1:0]  frozen_ff, frozen_in;
   logic             paused_ff, paused_in;

   // captured request
   logic [3:0]       cmd_ff;
   logic [NOW_W-1:0] now_ff;
   logic [ARG_W-1:0] arg_ff;
   logic             clamp_ff;

   logic [PROD_W-1:0] prod_ff;

   // response register
   logic              rv_ff, rv_in;
   logic              exp_ff, exp_in;
   logic              pau_ff, pau_in;
   logic              sta_ff, sta_in;
   logic [NOW_W-1:0]  ela_ff, ela_in;
   logic [IV_W-1:0]   prg_ff, prg_in;
   logic [TIMES_W-1:0] tim_ff, tim_in;
   logic [IV_W-1:0]   lft_ff, lft_in;

   // working signals
   logic [ST_W-1:0]   now_x;
   logic [ST_W-1:0]   iv_x;
   logic [ST_W-1:0]   mod_x;
   logic [RAW_W-1:0]  raw;
   logic [ST_W-1:0]   e_cur;
   logic              arg_neg;
   logic              arg_pos;
   logic [ARG_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] rnd;
   logic [ST_W-1:0]   off_mag;
   logic [ST_W-1:0]   off;
   logic              div_done;
   logic [DVD_W-1:0]  quot;
   logic [IV_W-1:0]   int_rem;
   logic [ST_W-1:0]   q_int;
   logic [ST_W-1:0]   t_lim;
   logic [IV_W-1:0]   prog_sat;

   pit_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (e_cur),
      .divisor  (iv_ff),
      .done     (div_done),
      .quotient (quot),
      .int_rem  (int_rem)
   );

   assign now_x   = {{(ST_W-NOW_W){1'b0}}, now_ff};
   assign iv_x    = {{(ST_W-IV_W){1'b0}}, iv_ff};
   assign mod_x   = {{(ST_W-IV_W){1'b0}}, int_rem};
   assign arg_neg = arg_ff[ARG_W-1];
   assign arg_pos = !arg_ff[ARG_W-1] && (arg_ff != '0);

   // signed elapsed time, then clamped at zero
   always_comb begin
      if (paused_ff) begin
         raw = {frozen_ff[ST_W-1], frozen_ff};
      end else begin
         raw = {{(RAW_W-NOW_W){1'b0}}, now_ff} - {start_ff[ST_W-1], start_ff};
      end
      e_cur = raw[RAW_W-1] ? '0 : raw[ST_W-1:0];
   end

   // set progress: offset = round(|arg| * interval / 2^16), sign restored
   assign mag     = arg_neg ? ARG_W'(~arg_ff + 1'b1) : arg_ff;
   assign prod    = {{(PROD_W-ARG_W){1'b0}}, mag} * {{(PROD_W-IV_W){1'b0}}, iv_ff};
   assign rnd     = prod_ff + ROUND_ADD;
   assign off_mag = rnd[FRAC_W+ST_W-1:FRAC_W];
   assign off     = arg_neg ? ST_W'(~off_mag + 1'b1) : off_mag;

   always_comb begin
      iv_in     = iv_ff;
      start_in  = start_ff;
      frozen_in = frozen_ff;
      paused_in = paused_ff;
      if (cfg_we) begin
         iv_in = (cfg_data == '0) ? IV_W'(1) : cfg_data;
      end
      if (ctl.apply) begin
         case (cmd_ff)
            CMD_START: begin
               start_in  = now_x;
               paused_in = 1'b0;
            end
            CMD_PAUSE: begin
               paused_in = 1'b1;
               frozen_in = now_x - start_ff;
            end
            CMD_RESUME: begin
               if (paused_ff) begin
                  paused_in = 1'b0;
                  start_in  = now_x - frozen_ff;
               end
            end
            CMD_EXPIRE: begin
               if (paused_ff) begin
                  frozen_in = iv_x;
               end else begin
                  start_in = now_x - iv_x;
               end
            end
            CMD_UNEXPIRE: begin
               start_in = now_x;
               if (paused_ff) begin
                  frozen_in = '0;
               end
            end
            CMD_DELAY: begin
               start_in = start_ff + {{(ST_W-ARG_W){arg_ff[ARG_W-1]}}, arg_ff};
            end
            CMD_SET_PROG: begin
               if (paused_ff) begin
                  frozen_in = off;
               end else begin
                  start_in = now_x - off;
               end
            end
            CMD_START_FRAC: begin
               start_in  = now_x - mod_x;
               paused_in = 1'b0;
            end
            CMD_START_REST: begin
               // no whole interval yet: wait out the rest of this one
               if (quot[DVD_W-1:FRAC_W] == '0) begin
                  start_in = now_x + iv_x - mod_x;
               end else begin
                  start_in = now_x - mod_x;
               end
               paused_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // result arithmetic on the state after the command
   always_comb begin
      q_int = quot[DVD_W-1:FRAC_W];
      if (arg_pos && (q_int > {{(ST_W-ARG_W){1'b0}}, arg_ff})) begin
         t_lim = {{(ST_W-ARG_W){1'b0}}, arg_ff};
      end else begin
         t_lim = q_int;
      end
      prog_sat = (quot[DVD_W-1:IV_W] != '0) ? '1 : quot[IV_W-1:0];

      exp_in = $signed(raw) >= $signed({{(RAW_W-IV_W){1'b0}}, iv_ff});
      pau_in = paused_ff;
      sta_in = $signed(start_ff) >= $signed(now_x);
      ela_in = (e_cur[ST_W-1:NOW_W] != '0) ? '1 : e_cur[NOW_W-1:0];
      prg_in = (clamp_ff && (prog_sat > PROG_ONE)) ? PROG_ONE : prog_sat;
      tim_in = (t_lim[ST_W-1:TIMES_W] != '0) ? '1 : t_lim[TIMES_W-1:0];
      lft_in = (e_cur >= iv_x) ? '0 : IV_W'(iv_ff - e_cur[IV_W-1:0]);
   end

   always_comb begin
      rv_in = rv_ff;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      if (ctl.load_rsp) begin
         rv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff     <= IV_W'(1);
         start_ff  <= '0;
         frozen_ff <= '0;
         paused_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         iv_ff     <= iv_in;
         start_ff  <= start_in;
         frozen_ff <= frozen_in;
         paused_ff <= paused_in;
         rv_ff     <= rv_in;
      end
      if (ctl.capture) begin
         cmd_ff   <= req_cmd;
         now_ff   <= req_now_ms;
         arg_ff   <= $unsigned(req_arg);
         clamp_ff <= req_clamp_progress;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod;
      end
      if (ctl.load_rsp) begin
         exp_ff <= exp_in;
         pau_ff <= pau_in;
         sta_ff <= sta_in;
         ela_ff <= ela_in;
         prg_ff <= prg_in;
         tim_ff <= tim_in;
         lft_ff <= lft_in;
      end
   end

   assign status.need_pre = (cmd_ff == CMD_START_FRAC) || (cmd_ff == CMD_START_REST);
   assign status.need_mul = (cmd_ff == CMD_SET_PROG);
   assign status.div_done = div_done;
   assign status.out_free = !rv_ff || !rsp_stall;

   assign rsp_valid         = rv_ff;
   assign rsp_expired       = exp_ff;
   assign rsp_is_paused     = pau_ff;
   assign rsp_started       = sta_ff;
   assign rsp_elapsed_ms    = ela_ff;
   assign rsp_progress      = prg_ff;
   assign rsp_times_expired = tim_ff;
   assign rsp_time_left_ms  = lft_ff;

endmodule
`default_nettype wire

@@ sv/pit_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pit_controller
// Sequencer for one command: capture, optional remainder division or
// product, state update, result division and response load.
// ----------------------------------------------------------------------------
module pit_controller (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   output logic                          csr_ready,
   input  wire pit_pkg::dp_status_type   status,
   output pit_pkg::ctl_cmd_type          ctl
);
   import pit_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b0_0000_0001,
      S_DISPATCH  = 9'b0_0000_0010,
      S_PRE_GO    = 9'b0_0000_0100,
      S_PRE_WAIT  = 9'b0_0000_1000,
      S_MUL       = 9'b0_0001_0000,
      S_APPLY     = 9'b0_0010_0000,
      S_POST_GO   = 9'b0_0100_0000,
      S_POST_WAIT = 9'b0_1000_0000,
      S_EMIT      = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.need_pre) begin
               state_in = S_PRE_GO;
            end else if (status.need_mul) begin
               state_in = S_MUL;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_PRE_GO:   state_in = S_PRE_WAIT;
         S_PRE_WAIT: begin
            if (status.div_done) begin
               state_in = S_APPLY;
            end
         end
         S_MUL:      state_in = S_APPLY;
         S_APPLY:    state_in = S_POST_GO;
         S_POST_GO:  state_in = S_POST_WAIT;
         S_POST_WAIT: begin
            if (status.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the previous beat has left the response register
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = (state_ff == S_IDLE);
   assign ctl.capture   = (state_ff == S_IDLE) && req_valid;
   assign ctl.div_start = (state_ff == S_PRE_GO) || (state_ff == S_POST_GO);
   assign ctl.mul_en    = (state_ff == S_MUL);
   assign ctl.apply     = (state_ff == S_APPLY);
   assign ctl.load_rsp  = (state_ff == S_EMIT) && status.out_free;

endmodule
`default_nettype wire

@@ sv/pausable_interval_timer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pausable_interval_timer
// Interval timer with pause, resume, restart variants and Q16.16 progress.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat (cmd, now_ms, arg, clamp_progress); it is
//   taken when req_valid is high and req_stall low. Each command returns one
//   rsp_* beat with the timer status after the command ran.
//   csr_* writes interval_ms; it is taken when csr_valid and csr_ready are
//   high, and csr_ready is high only while no command is in progress.
//   Every command runs a division of its elapsed time; set progress first
//   registers a product, and the two restart-from-remainder commands divide
//   twice. A new command can be taken in the cycle after the response is
//   loaded, and not while a command is in progress. The restoring divider
//   has 58 steps (42 integer plus 16 fraction bits).
//   Reset clears the timer state (start 0, frozen 0, running), sets the
//   interval to one and drops any pending response.
//   When rsp_stall is high the response beat holds; the next command can
//   still be taken and worked, and waits to load until the beat has left.
// ----------------------------------------------------------------------------
module pausable_interval_timer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [3:0]                       req_cmd,
   input  wire logic [pit_pkg::NOW_W-1:0]        req_now_ms,
   input  wire logic signed [pit_pkg::ARG_W-1:0] req_arg,
   input  wire logic                             req_clamp_progress,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_expired,
   output logic                                  rsp_is_paused,
   output logic                                  rsp_started,
   output logic [pit_pkg::NOW_W-1:0]             rsp_elapsed_ms,
   output logic [pit_pkg::IV_W-1:0]              rsp_progress,
   output logic [pit_pkg::TIMES_W-1:0]           rsp_times_expired,
   output logic [pit_pkg::IV_W-1:0]              rsp_time_left_ms,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pit_pkg::IV_W-1:0]         csr_data
);
   import pit_pkg::*;

   ctl_cmd_type   ctl;
   dp_status_type status;
   logic          cfg_we;

   assign cfg_we = csr_valid && csr_ready;

   pit_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .ctl       (ctl)
   );

   pit_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .status             (status),
      .cfg_we             (cfg_we),
      .cfg_data           (csr_data),
      .req_cmd            (req_cmd),
      .req_now_ms         (req_now_ms),
      .req_arg            (req_arg),
      .req_clamp_progress (req_clamp_progress),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_expired        (rsp_expired),
      .rsp_is_paused      (rsp_is_paused),
      .rsp_started        (rsp_started),
      .rsp_elapsed_ms     (rsp_elapsed_ms),
      .rsp_progress       (rsp_progress),
      .rsp_times_expired  (rsp_times_expired),
      .rsp_time_left_ms   (rsp_time_left_ms)
   );

endmodule
`default_nettype wire

@@ sv/pit_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks on the pausable interval timer, bound to the top level.
// ----------------------------------------------------------------------------
module pit_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic                             rsp_expired,
   input  wire logic [pit_pkg::TIMES_W-1:0]      rsp_times_expired,
   input  wire logic [pit_pkg::IV_W-1:0]         rsp_time_left_ms
);
   import pit_pkg::*;

   // a stalled response beat stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // one command at a time: an accepted beat closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a command is in progress");

   // no time left exactly when the interval has been reached
   a_left_vs_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_expired == (rsp_time_left_ms == '0)))
      else $error("time left disagrees with expired flag");

   // no whole interval can have passed before expiry
   a_times_vs_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_expired |-> (rsp_times_expired == '0))
      else $error("intervals counted before expiry");

endmodule

bind pausable_interval_timer pit_checker u_pit_checker (.*);
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pausable interval timer. A shadow copy of the
// timer state predicts the status beat of every accepted command, and each
// response beat is compared field by field with the oldest prediction.
// Directed commands come first, then random commands over several interval
// settings, with random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_top;

   import pit_pkg::*;

   localparam logic [3:0]       CMD_FIRST_UNUSED = 4'd10;
   localparam logic [3:0]       CMD_LAST_UNUSED  = 4'd15;
   localparam logic [NOW_W-1:0] NOW_MAX          = '1;
   localparam int               PHASE_ITEMS      = 240;

   typedef struct packed {
      logic                 expired;
      logic                 is_paused;
      logic                 started;
      logic [NOW_W-1:0]     elapsed_ms;
      logic [IV_W-1:0]      progress;
      logic [TIMES_W-1:0]   times_expired;
      logic [IV_W-1:0]      time_left_ms;
   } timer_status_type;

   logic                     clock;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic                     req_stall;
   logic [3:0]               req_cmd            = CMD_QUERY;
   logic [NOW_W-1:0]         req_now_ms         = '0;
   logic signed [ARG_W-1:0]  req_arg            = '0;
   logic                     req_clamp_progress = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall          = 1'b0;
   logic                     rsp_expired;
   logic                     rsp_is_paused;
   logic                     rsp_started;
   logic [NOW_W-1:0]         rsp_elapsed_ms;
   logic [IV_W-1:0]          rsp_progress;
   logic [TIMES_W-1:0]       rsp_times_expired;
   logic [IV_W-1:0]          rsp_time_left_ms;
   logic                     csr_valid          = 1'b0;
   logic                     csr_ready;
   logic [IV_W-1:0]          csr_data           = '0;

   // shadow of the timer state
   longint                   shadow_start  = 0;
   longint                   shadow_frozen = 0;
   logic                     shadow_paused = 1'b0;
   logic [IV_W-1:0]          shadow_interval = 32'd1;

   timer_status_type         status_q[$];
   logic [NOW_W-1:0]         wall_ms = '0;
   int                       mismatch_count = 0;
   int                       items_sent     = 0;
   int                       results_seen   = 0;
   int                       interval_writes = 0;
   int                       rsp_hold_len   = 0;
   bit                       req_no_idle    = 1'b0;
   bit                       rsp_no_idle    = 1'b0;

   pausable_interval_timer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_now_ms         (req_now_ms),
      .req_arg            (req_arg),
      .req_clamp_progress (req_clamp_progress),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_expired        (rsp_expired),
      .rsp_is_paused      (rsp_is_paused),
      .rsp_started        (rsp_started),
      .rsp_elapsed_ms     (rsp_elapsed_ms),
      .rsp_progress       (rsp_progress),
      .rsp_times_expired  (rsp_times_expired),
      .rsp_time_left_ms   (rsp_time_left_ms),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------
   function automatic longint wrap42(logic [63:0] v);
      return {{(64 - ST_W){v[ST_W-1]}}, v[ST_W-1:0]};
   endfunction

   function automatic longint raw_elapsed(longint now_s);
      return shadow_paused ? shadow_frozen : now_s - shadow_start;
   endfunction

   function automatic timer_status_type step_timer(logic [3:0] cmd, logic [NOW_W-1:0] now_ms,
                                                   logic signed [ARG_W-1:0] arg, logic clamp);
      longint           now_s;
      longint           arg_s;
      longint           iv_s;
      longint           raw;
      longint unsigned  iv;
      longint unsigned  e;
      longint unsigned  r;
      longint unsigned  mag;
      longint unsigned  off;
      longint unsigned  prog;
      longint unsigned  times;
      longint unsigned  left;
      timer_status_type st;
      now_s = longint'({24'd0, now_ms});
      arg_s = longint'(arg);
      iv    = {32'd0, shadow_interval};
      iv_s  = longint'(iv);
      raw   = raw_elapsed(now_s);
      e     = raw < 0 ? 64'd0 : raw;
      case (cmd)
         CMD_START: begin
            shadow_start  = now_s;
            shadow_paused = 1'b0;
         end
         CMD_PAUSE: begin
            shadow_paused = 1'b1;
            shadow_frozen = wrap42(now_s - shadow_start);
         end
         CMD_RESUME: begin
            if (shadow_paused) begin
               shadow_paused = 1'b0;
               shadow_start  = wrap42(now_s - shadow_frozen);
            end
         end
         CMD_EXPIRE: begin
            if (shadow_paused) shadow_frozen = iv_s;
            else shadow_start = now_s - iv_s;
         end
         CMD_UNEXPIRE: begin
            shadow_start = now_s;
            if (shadow_paused) shadow_frozen = 0;
         end
         CMD_DELAY: shadow_start = wrap42(shadow_start + arg_s);
         CMD_SET_PROG: begin
            // round to nearest, halves away from zero
            mag = arg_s < 0 ? -arg_s : arg_s;
            r   = (mag * iv + 64'd32768) >> FRAC_W;
            off = arg_s < 0 ? 64'd0 - r : r;
            if (shadow_paused) shadow_frozen = wrap42(off);
            else shadow_start = wrap42(now_s - off);
         end
         CMD_START_FRAC: begin
            shadow_start  = wrap42(now_s - (e % iv));
            shadow_paused = 1'b0;
         end
         CMD_START_REST: begin
            r = e % iv;
            if (e / iv == 0) shadow_start = wrap42(now_s + iv_s - r);
            else shadow_start = wrap42(now_s - r);
            shadow_paused = 1'b0;
         end
         default: ;
      endcase
      raw   = raw_elapsed(now_s);
      e     = raw < 0 ? 64'd0 : raw;
      prog  = (e << FRAC_W) / iv;
      times = e / iv;
      left  = e >= iv ? 64'd0 : iv - e;
      if (prog > 64'hFFFF_FFFF) prog = 64'hFFFF_FFFF;
      if (clamp && prog > 64'h1_0000) prog = 64'h1_0000;
      if (arg_s > 0 && longint'(times) > arg_s) times = arg_s;
      if (times > 64'hFFFF) times = 64'hFFFF;
      st.expired       = raw >= iv_s;
      st.is_paused     = shadow_paused;
      st.started       = shadow_start >= now_s;
      st.elapsed_ms    = e > {24'd0, NOW_MAX} ? NOW_MAX : e[NOW_W-1:0];
      st.progress      = prog[IV_W-1:0];
      st.times_expired = times[TIMES_W-1:0];
      st.time_left_ms  = left[IV_W-1:0];
      return st;
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      timer_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: response beat with nothing outstanding: expected none, actual %0h",
                     $time, rsp_elapsed_ms);
         end else begin
            want = status_q.pop_front();
            check_field("expired", 64'(want.expired), 64'(rsp_expired));
            check_field("is_paused", 64'(want.is_paused), 64'(rsp_is_paused));
            check_field("started", 64'(want.started), 64'(rsp_started));
            check_field("elapsed_ms", 64'(want.elapsed_ms), 64'(rsp_elapsed_ms));
            check_field("progress", 64'(want.progress), 64'(rsp_progress));
            check_field("times_expired", 64'(want.times_expired), 64'(rsp_times_expired));
            check_field("time_left_ms", 64'(want.time_left_ms), 64'(rsp_time_left_ms));
            results_seen++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Idling on both channels
   // -------------------------------------------------------------------------
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 96) return $urandom_range(4, 20);
      return $urandom_range(30, 200);
   endfunction

   function automatic longint unsigned rand_below(longint unsigned n);
      return {$urandom, $urandom} % n;
   endfunction

   initial begin : rsp_stall_gen
      int busy_left;
      int free_left;
      busy_left = 0;
      free_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            // long hold-off: let the block fill up behind the held beat
            rsp_stall <= 1'b1;
            rsp_hold_len--;
         end else if (rsp_no_idle) begin
            rsp_stall <= 1'b0;
         end else if (busy_left > 0) begin
            rsp_stall <= 1'b1;
            busy_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            busy_left = gap_len();
            free_left = $urandom_range(1, 40);
            rsp_stall <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driving
   // -------------------------------------------------------------------------
   // Valid stays high after the beat is taken; the caller either sends the
   // next beat in the same step or calls drain_results, which drops it.
   task automatic send_cmd(logic [3:0] cmd, logic [NOW_W-1:0] now_ms,
                           logic signed [ARG_W-1:0] arg, logic clamp);
      int gap;
      gap = req_no_idle ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_now_ms         <= now_ms;
      req_arg            <= arg;
      req_clamp_progress <= clamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      status_q.push_back(step_timer(cmd, now_ms, arg, clamp));
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_interval(logic [IV_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_interval = value == '0 ? 32'd1 : value;
      interval_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_cmd();
      logic [3:0]              cmd;
      logic signed [ARG_W-1:0] arg;
      longint unsigned         span;
      longint unsigned         lim;
      int                      p;
      p = $urandom_range(0, 99);
      if (p < 90) cmd = 4'($urandom_range(CMD_QUERY, CMD_START_REST));
      else cmd = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));

      // timestamps mostly walk forward on the scale of the interval
      span = {32'd0, shadow_interval} * 2 + 2;
      p = $urandom_range(0, 99);
      if (p < 70) wall_ms = wall_ms + NOW_W'(rand_below(span));
      else if (p < 80) wall_ms = wall_ms - NOW_W'(rand_below(span));
      else if (p < 92) wall_ms = NOW_W'({$urandom, $urandom});
      else if (p < 96) wall_ms = NOW_MAX - NOW_W'(rand_below(span));
      else wall_ms = NOW_W'(rand_below(span));

      lim = span > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : span;
      p = $urandom_range(0, 99);
      if (cmd == CMD_DELAY && p < 60)
         arg = ARG_W'(longint'($urandom_range(0, 32'(lim))) - longint'(lim / 2));
      else if (cmd == CMD_SET_PROG && p < 60)
         arg = $urandom_range(0, 32'h1_8000);
      else if (cmd == CMD_SET_PROG && p < 80)
         arg = ARG_W'(-longint'($urandom_range(0, 32'h1_8000)));
      else if (p < 35)
         arg = '0;
      else if (p < 65)
         arg = $urandom_range(1, 8);
      else if (p < 75)
         arg = ARG_W'(-longint'($urandom_range(1, 8)));
      else
         arg = $urandom;
      send_cmd(cmd, wall_ms, arg, 1'($urandom_range(0, 1)));
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_reset_state();
      send_cmd(CMD_QUERY, '0, '0, 1'b0);
      send_cmd(CMD_QUERY, NOW_MAX, '0, 1'b0);
      send_cmd(CMD_QUERY, NOW_MAX, 32'sd5, 1'b1);
   endtask

   task automatic test_each_command();
      write_interval(32'd1000);
      send_cmd(CMD_START, 40'd5000, '0, 1'b0);
      send_cmd(CMD_QUERY, 40'd5500, '0, 1'b0);
      send_cmd(CMD_QUERY, 40'd7500, '0, 1'b1);
      send_cmd(CMD_QUERY, 40'd7500, 32'sd1, 1'b0);
      send_cmd(CMD_PAUSE, 40'd8000, '0, 1'b0);
      // pausing again recomputes the frozen time
      send_cmd(CMD_PAUSE, 40'd8200, '0, 1'b0);
      send_cmd(CMD_QUERY, 40'd20000, 32'sh7FFF_FFFF, 1'b0);
      send_cmd(CMD_RESUME, 40'd21000, '0, 1'b0);
      send_cmd(CMD_RESUME, 40'd21500, '0, 1'b0);
      send_cmd(CMD_EXPIRE, 40'd22000, '0, 1'b0);
      send_cmd(CMD_PAUSE, 40'd22100, '0, 1'b0);
      send_cmd(CMD_EXPIRE, 40'd22200, -32'sd1, 1'b0);
      send_cmd(CMD_UNEXPIRE, 40'd22300, '0, 1'b0);
      send_cmd(CMD_RESUME, 40'd22400, '0, 1'b0);
      send_cmd(CMD_UNEXPIRE, 40'd22500, '0, 1'b0);
      send_cmd(CMD_DELAY, 40'd22600, 32'sd300, 1'b0);
      send_cmd(CMD_DELAY, 40'd22700, 32'sh8000_0000, 1'b0);
      send_cmd(CMD_SET_PROG, 40'd23000, 32'sh0000_8000, 1'b1);
      send_cmd(CMD_SET_PROG, 40'd23000, -32'sd32768, 1'b0);
      send_cmd(CMD_SET_PROG, 40'd23100, 32'sh7FFF_FFFF, 1'b0);
      send_cmd(CMD_START_FRAC, 40'd23200, '0, 1'b0);
      // restart with rest, first inside the first interval, then past it
      send_cmd(CMD_START, 40'd30000, '0, 1'b0);
      send_cmd(CMD_START_REST, 40'd30400, '0, 1'b0);
      send_cmd(CMD_START_REST, 40'd32500, '0, 1'b0);
      send_cmd(CMD_FIRST_UNUSED, 40'd33000, '0, 1'b0);
      send_cmd(CMD_LAST_UNUSED, 40'd33000, '0, 1'b1);
      wall_ms = 40'd33000;
   endtask

   task automatic test_backpressure();
      int n;
      rsp_hold_len = 3000;
      req_no_idle  = 1'b1;
      for (n = 0; n < 8; n++) send_random_cmd();
      req_no_idle = 1'b0;
      drain_results();
   endtask

   task automatic test_random_phases();
      logic [IV_W-1:0] iv;
      int              phase;
      int              n;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       iv = '0;
            1:       iv = $urandom_range(2, 16);
            2:       iv = $urandom_range(100, 5000);
            3:       iv = 32'hFFFF_FFFF;
            4:       iv = $urandom;
            5:       iv = 32'h0001_0000;
            6:       iv = $urandom_range(1, 3);
            default: iv = $urandom_range(17, 99999);
         endcase
         write_interval(iv);
         req_no_idle = phase == 2;
         rsp_no_idle = phase == 2 || phase == 5;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_random_cmd();
            // now and then pause the sender until everything is back
            if ($urandom_range(0, 99) == 0) drain_results();
         end
         req_no_idle = 1'b0;
         rsp_no_idle = 1'b0;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_each_command();
      test_backpressure();
      test_random_phases();
      drain_results();
      repeat (140) @(posedge clock);
      $display("Sent %0d commands, checked %0d status beats over %0d interval writes,",
               items_sent, results_seen, interval_writes);
      $display("covering every command, unused codes, stalls and a long response hold-off.");
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/pit_pkg.sv
sv/pit_divider.sv
sv/pit_datapath.sv
sv/pit_controller.sv
sv/pausable_interval_timer.sv
sv/pit_checker.sv
bench/tb_top.sv
